// File: rtl/bfa_pkg.sv
`timescale 1ns / 1ps

package bfa_pkg;

  // default sizes
  localparam int MaxExtentsDef    = 16;
  localparam int PageIndexBitsDef = 16;

  // command codes
  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_ALLOC = 1'b1
  } extent_cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    RES_OK     = 2'd0,
    RES_NO_FIT = 2'd1,
    RES_FULL   = 2'd2
  } res_status_e;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_SHIFT,
    S_ADD_DRAIN,
    S_ADD_PUT,
    S_SCAN,
    S_SCAN_LAST,
    S_PICK,
    S_CLOSE,
    S_CLOSE_DRAIN,
    S_DONE
  } bfa_state_e;

  // table index counter operations
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_TOP,
    IDX_ZERO,
    IDX_AFTER_BEST,
    IDX_UP,
    IDX_DOWN
  } idx_op_e;

  // table write operations
  typedef enum logic [2:0] {
    WR_NONE,
    WR_SHIFT_UP,
    WR_SHIFT_DOWN,
    WR_NEW,
    WR_TRIM
  } wr_op_e;

  // controller to datapath commands
  typedef struct packed {
    logic    capture;
    idx_op_e idx_op;
    logic    rd_en;
    wr_op_e  wr_op;
    logic    scan;
    logic    total_inc;
    logic    total_dec;
    logic    set_full;
    logic    set_nofit;
    logic    take_base;
    logic    finish;
  } bfa_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic is_alloc;
    logic table_full;
    logic table_empty;
    logic idx_zero;
    logic idx_last;
    logic found;
    logic exact;
    logic best_last;
  } bfa_sts_t;

endpackage

// File: rtl/best_fit_page_extent_allocator_core.sv
`timescale 1ns / 1ps
// an add shifts each held extent up one slot, one table shift per cycle, then writes
// the new extent into slot 0; an add to a full table only reports full; an allocate
// makes one scan read per cycle with an early stop on an exact fit, then trims the
// best entry or removes it and closes up the entries after it, else reports no fit
// one command in flight, busy drops in the result beat, which lasts one cycle and the
// receiver cannot stall it; reset empties the extent table, contents are not cleared
module best_fit_page_extent_allocator_core #(
  parameter int MAX_EXTENTS     = bfa_pkg::MaxExtentsDef,
  parameter int PAGE_INDEX_BITS = bfa_pkg::PageIndexBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        command_i,
  input  logic [15:0] first_page_i,
  input  logic [15:0] page_count_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] base_page_o,
  output logic [4:0]  extents_held_o
);
  import bfa_pkg::*;

  bfa_ctl_t ctl;
  bfa_sts_t sts;

  // sequencer
  bfa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  // extent table and best fit datapath
  bfa_dpath #(
    .MAX_EXTENTS     (MAX_EXTENTS),
    .PAGE_INDEX_BITS (PAGE_INDEX_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .command_i      (command_i),
    .first_page_i   (first_page_i),
    .page_count_i   (page_count_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .base_page_o    (base_page_o),
    .extents_held_o (extents_held_o)
  );

endmodule

// File: rtl/bfa_ctrl.sv
`timescale 1ns / 1ps

module bfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  bfa_pkg::bfa_sts_t sts_i,
  output bfa_pkg::bfa_ctl_t ctl_o
);
  import bfa_pkg::*;

  bfa_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (sts_i.is_alloc) begin
          state_d = sts_i.table_empty ? S_DONE : S_SCAN;
        end else if (sts_i.table_full) begin
          state_d = S_DONE;
        end else begin
          state_d = sts_i.table_empty ? S_ADD_PUT : S_ADD_SHIFT;
        end
      end
      S_ADD_SHIFT: begin
        if (sts_i.idx_zero) state_d = S_ADD_DRAIN;
      end
      S_ADD_DRAIN: state_d = S_ADD_PUT;
      S_ADD_PUT:   state_d = S_DONE;
      S_SCAN: begin
        // stop early once an exact fit is held
        if (sts_i.exact) begin
          state_d = S_PICK;
        end else if (sts_i.idx_last) begin
          state_d = S_SCAN_LAST;
        end
      end
      S_SCAN_LAST: state_d = S_PICK;
      S_PICK: begin
        if (sts_i.found && sts_i.exact && !sts_i.best_last) begin
          state_d = S_CLOSE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CLOSE: begin
        if (sts_i.idx_last) state_d = S_CLOSE_DRAIN;
      end
      S_CLOSE_DRAIN: state_d = S_DONE;
      S_DONE:        state_d = S_IDLE;
      default:       state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    ctl_o = '0;
    case (state_q)
      S_IDLE: begin
        ctl_o.capture = start;
      end
      S_DECODE: begin
        if (sts_i.is_alloc) begin
          if (sts_i.table_empty) ctl_o.set_nofit = 1'b1;
          else                   ctl_o.idx_op    = IDX_ZERO;
        end else if (sts_i.table_full) begin
          ctl_o.set_full = 1'b1;
        end else if (!sts_i.table_empty) begin
          ctl_o.idx_op = IDX_TOP;
        end
      end
      S_ADD_SHIFT: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.idx_op = IDX_DOWN;
        ctl_o.wr_op  = WR_SHIFT_UP;
      end
      S_ADD_DRAIN: begin
        ctl_o.wr_op = WR_SHIFT_UP;
      end
      S_ADD_PUT: begin
        ctl_o.wr_op     = WR_NEW;
        ctl_o.total_inc = 1'b1;
      end
      S_SCAN: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.idx_op = IDX_UP;
        ctl_o.scan   = 1'b1;
      end
      S_SCAN_LAST: begin
        ctl_o.scan = 1'b1;
      end
      S_PICK: begin
        if (!sts_i.found) begin
          ctl_o.set_nofit = 1'b1;
        end else begin
          ctl_o.take_base = 1'b1;
          if (!sts_i.exact) begin
            ctl_o.wr_op = WR_TRIM;
          end else if (sts_i.best_last) begin
            ctl_o.total_dec = 1'b1;
          end else begin
            ctl_o.idx_op = IDX_AFTER_BEST;
          end
        end
      end
      S_CLOSE: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.idx_op = IDX_UP;
        ctl_o.wr_op  = WR_SHIFT_DOWN;
      end
      S_CLOSE_DRAIN: begin
        ctl_o.wr_op     = WR_SHIFT_DOWN;
        ctl_o.total_dec = 1'b1;
      end
      S_DONE: begin
        ctl_o.finish = 1'b1;
      end
      default: ctl_o = '0;
    endcase
  end

endmodule

// File: rtl/bfa_dpath.sv
`timescale 1ns / 1ps

module bfa_dpath #(
  parameter int MAX_EXTENTS     = bfa_pkg::MaxExtentsDef,
  parameter int PAGE_INDEX_BITS = bfa_pkg::PageIndexBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfa_pkg::bfa_ctl_t ctl_i,
  output bfa_pkg::bfa_sts_t sts_o,
  input  logic              command_i,
  input  logic [15:0]       first_page_i,
  input  logic [15:0]       page_count_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [15:0]       base_page_o,
  output logic [4:0]        extents_held_o
);
  import bfa_pkg::*;

  localparam int TW = $clog2(MAX_EXTENTS + 1);
  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int PW = PAGE_INDEX_BITS;
  localparam int EW = 2 * PW;

  // extent table, entry = {start, size}
  logic [EW-1:0] mem [MAX_EXTENTS];

  logic          cmd_q;
  logic [PW-1:0] first_q, count_q;
  logic [TW-1:0] total_q, total_d, total_m1;
  logic [IW-1:0] idx_q, idx_d;
  logic [EW-1:0] rd_q;
  logic [IW-1:0] rd_addr_q;
  logic          rd_vld_q;
  logic          found_q;
  logic [IW-1:0] best_q;
  logic [PW-1:0] best_left_q, best_start_q;
  res_status_e   status_q;
  logic [PW-1:0] base_q;
  logic          done_q;

  logic [PW+15:0] first_ext, count_ext;
  logic [PW+15:0] base_ext;
  logic [TW+4:0]  total_ext;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [PW-1:0] cand_size, cand_start, cand_left;
  logic          cand_take;

  // input fields fitted to the page index width
  assign first_ext = {{PW{1'b0}}, first_page_i};
  assign count_ext = {{PW{1'b0}}, page_count_i};

  assign total_m1 = total_q - TW'(1);

  // index counter
  always_comb begin
    case (ctl_i.idx_op)
      IDX_HOLD:       idx_d = idx_q;
      IDX_TOP:        idx_d = IW'(total_m1);
      IDX_ZERO:       idx_d = '0;
      IDX_AFTER_BEST: idx_d = best_q + IW'(1);
      IDX_UP:         idx_d = idx_q + IW'(1);
      IDX_DOWN:       idx_d = idx_q - IW'(1);
      default:        idx_d = idx_q;
    endcase
  end

  // extent count
  always_comb begin
    total_d = total_q;
    if (ctl_i.total_inc) total_d = total_q + TW'(1);
    if (ctl_i.total_dec) total_d = total_m1;
  end

  // table write select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr_q;
    wr_data = rd_q;
    case (ctl_i.wr_op)
      WR_NONE: wr_en = 1'b0;
      WR_SHIFT_UP: begin
        wr_en   = rd_vld_q;
        wr_addr = rd_addr_q + IW'(1);
      end
      WR_SHIFT_DOWN: begin
        wr_en   = rd_vld_q;
        wr_addr = rd_addr_q - IW'(1);
      end
      WR_NEW: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = {first_q, count_q};
      end
      WR_TRIM: begin
        wr_en   = 1'b1;
        wr_addr = best_q;
        wr_data = {best_start_q + count_q, best_left_q};
      end
      default: wr_en = 1'b0;
    endcase
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (ctl_i.rd_en) begin
      rd_q      <= mem[idx_q];
      rd_addr_q <= idx_q;
    end
  end

  // best fit compare on the entry just read
  assign cand_size  = rd_q[PW-1:0];
  assign cand_start = rd_q[EW-1:PW];
  assign cand_left  = cand_size - count_q;
  assign cand_take  = ctl_i.scan && rd_vld_q && (cand_size >= count_q) &&
                      (!found_q || (cand_left < best_left_q));

  // command fields and best candidate
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q   <= command_i;
      first_q <= first_ext[PW-1:0];
      count_q <= count_ext[PW-1:0];
    end
    if (cand_take) begin
      best_q       <= rd_addr_q;
      best_left_q  <= cand_left;
      best_start_q <= cand_start;
    end
    idx_q <= idx_d;
  end

  // result fields
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      status_q <= RES_OK;
      base_q   <= '0;
    end else begin
      if (ctl_i.set_full)  status_q <= RES_FULL;
      if (ctl_i.set_nofit) status_q <= RES_NO_FIT;
      if (ctl_i.take_base) base_q   <= best_start_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      total_q  <= total_d;
      rd_vld_q <= ctl_i.rd_en;
      done_q   <= ctl_i.finish;
      if (ctl_i.capture)  found_q <= 1'b0;
      else if (cand_take) found_q <= 1'b1;
    end
  end

  // status to controller
  always_comb begin
    sts_o.is_alloc    = (cmd_q == CMD_ALLOC);
    sts_o.table_full  = (total_q == TW'(MAX_EXTENTS));
    sts_o.table_empty = (total_q == '0);
    sts_o.idx_zero    = (idx_q == '0);
    sts_o.idx_last    = (TW'(idx_q) == total_m1);
    sts_o.found       = found_q;
    sts_o.exact       = found_q && (best_left_q == '0);
    sts_o.best_last   = (TW'(best_q) == total_m1);
  end

  // result beat
  assign base_ext       = {16'd0, base_q};
  assign total_ext      = {5'd0, total_q};
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign base_page_o    = base_ext[15:0];
  assign extents_held_o = total_ext[4:0];

  // count never passes the table depth
  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(MAX_EXTENTS))
    else $error("extent count beyond table depth");

  // no shift write may still be pending when the new extent goes in
  a_new_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.wr_op == WR_NEW) |-> !rd_vld_q)
    else $error("new extent write collides with shift");

  // removal only from a non-empty table
  a_dec_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.total_dec |-> (total_q != '0))
    else $error("extent removed from empty table");

  // full status only with a full table
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q == RES_FULL)) |-> (total_q == TW'(MAX_EXTENTS)))
    else $error("full status with room left");

  // a result beat is never longer than one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held");

endmodule
